### sv/tvag_pkg.sv
// Shared types, widths and the restoring division step of the tiled volume address generator.
package tvag_pkg;

   localparam int DIM_W   = 11;
   localparam int COORD_W = 12;
   localparam int OFS_W   = 33;
   localparam int STEP_W  = 34;
   localparam int NAXES   = 3;
   localparam int IDX_W   = 3;

   localparam logic [IDX_W-1:0] REG_SIZE_X  = 3'd0;
   localparam logic [IDX_W-1:0] REG_SIZE_Y  = 3'd1;
   localparam logic [IDX_W-1:0] REG_SIZE_Z  = 3'd2;
   localparam logic [IDX_W-1:0] REG_BRICK_X = 3'd3;
   localparam logic [IDX_W-1:0] REG_BRICK_Y = 3'd4;
   localparam logic [IDX_W-1:0] REG_BRICK_Z = 3'd5;
   localparam logic [IDX_W-1:0] REG_BORDER  = 3'd6;

   typedef logic [NAXES-1:0][DIM_W-1:0] dim_vec_type;

   // One axis while its wrapped index is divided by the brick edge.
   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] quo;
      logic [DIM_W-1:0] rem;
   } div_axis_type;

   typedef div_axis_type [NAXES-1:0] div_vec_type;

   // One restoring division step: returns {new remainder, quotient bit}.
   function automatic logic [DIM_W:0] div_step(input logic [DIM_W-1:0] rem,
                                               input logic             dbit,
                                               input logic [DIM_W-1:0] divisor);
      logic [DIM_W:0] rem_sh;
      logic [DIM_W:0] diff;
      rem_sh = {rem, dbit};
      diff   = rem_sh - {1'b0, divisor};
      if (rem_sh >= {1'b0, divisor}) begin
         div_step = {diff[DIM_W-1:0], 1'b1};
      end else begin
         div_step = {rem_sh[DIM_W-1:0], 1'b0};
      end
   endfunction

endpackage

### sv/tvag_div_stage.sv
// One pipeline stage of the three-axis restoring divider (index by brick edge).
module tvag_div_stage
   import tvag_pkg::*;
#(
   parameter int FIRST_BIT = 10,
   parameter int STEPS     = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  div_vec_type in_axes,
   input  dim_vec_type brick,
   output logic        out_valid,
   output div_vec_type out_axes
);

   logic        valid_ff;
   div_vec_type axes_ff;
   div_vec_type axes_in;

   always_comb begin
      logic [DIM_W:0] res;
      axes_in = in_axes;
      for (int a = 0; a < NAXES; a++) begin
         for (int s = 0; s < STEPS; s++) begin
            res = div_step(axes_in[a].rem, axes_in[a].w[FIRST_BIT-s], brick[a]);
            axes_in[a].rem = res[DIM_W:1];
            axes_in[a].quo[FIRST_BIT-s] = res[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         axes_ff <= axes_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_axes  = axes_ff;

endmodule

### sv/tiled_volume_address_gen.sv
// Top level of the tiled volume address generator: coordinate to bricked offset and steps.
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_stall   req_coord_x, req_coord_y, req_coord_z
//   rsp       out        rsp_valid / rsp_stall   rsp_offset, rsp_step_x/y/z, rsp_outside
//   csr       in         csr_write_en            csr_index, csr_data
//
// One transaction can enter every cycle while req_stall is low; each transaction passes
// through the seven-stage pipeline (wrap, three divider stages, multiply, jump sum,
// offset sum) to the result register.
// After reset and after every register write, a sequencer derives the brick counts,
// brick volume and per-axis strides; req_stall is high while it runs.
// A stalled result holds the whole pipeline in place, so nothing is lost or repeated.
module tiled_volume_address_gen
   import tvag_pkg::*;
#(
   parameter int MAX_DIM = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic        [OFS_W-1:0]   rsp_offset,
   output logic signed [STEP_W-1:0]  rsp_step_x,
   output logic signed [STEP_W-1:0]  rsp_step_y,
   output logic signed [STEP_W-1:0]  rsp_step_z,
   output logic                      rsp_outside,
   input  logic                      csr_write_en,
   input  logic        [IDX_W-1:0]   csr_index,
   input  logic        [DIM_W-1:0]   csr_data
);

   localparam int SEQ_DIV_BITS = DIM_W + 1;
   localparam int SEQ_LAST     = SEQ_DIV_BITS + 5;
   localparam int CNT_W        = $clog2(SEQ_LAST + 1);

   // Raw configuration registers.
   dim_vec_type      size_ff;
   dim_vec_type      brick_ff;
   logic [DIM_W-1:0] border_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NAXES; a++) begin
            size_ff[a]  <= DIM_W'(1);
            brick_ff[a] <= DIM_W'(1);
         end
         border_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_SIZE_X:  size_ff[0]  <= csr_data;
            REG_SIZE_Y:  size_ff[1]  <= csr_data;
            REG_SIZE_Z:  size_ff[2]  <= csr_data;
            REG_BRICK_X: brick_ff[0] <= csr_data;
            REG_BRICK_Y: brick_ff[1] <= csr_data;
            REG_BRICK_Z: brick_ff[2] <= csr_data;
            REG_BORDER:  border_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Saturated sizes, bricks (zero treated as one) and per-axis clamped border.
   dim_vec_type      size_s;
   dim_vec_type      brick_s;
   dim_vec_type      bw_s;
   logic [DIM_W-1:0] border_s;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
      if (32'(v) > MAX_DIM) begin
         sat_dim = DIM_W'(MAX_DIM);
      end else begin
         sat_dim = v;
      end
   endfunction

   always_comb begin
      border_s = sat_dim(border_ff);
      for (int a = 0; a < NAXES; a++) begin
         size_s[a]  = sat_dim(size_ff[a]);
         brick_s[a] = (brick_ff[a] == '0) ? DIM_W'(1) : sat_dim(brick_ff[a]);
         bw_s[a]    = (border_s > size_s[a]) ? size_s[a] : border_s;
      end
   end

   // Derived-constant sequencer: brick counts by restoring division, then products.
   logic                    restart_ff;
   logic                    busy_ff;
   logic [CNT_W-1:0]        seq_cnt_ff;
   logic [DIM_W:0]          dd_x_ff, dd_y_ff;
   logic [DIM_W-1:0]        rem_x_ff, rem_y_ff;
   logic [DIM_W:0]          nbx_ff, nby_ff;
   logic [2*DIM_W-1:0]      inner_z_ff;
   logic [STEP_W-1:0]       vol_ff, outer_y_ff, outer_z_ff;
   logic [2*DIM_W-1:0]      mul_y_ff;
   logic [OFS_W-1:0]        mul_z_ff;
   logic signed [STEP_W-1:0] carry_ff [NAXES];

   logic [DIM_W:0] dstep_x, dstep_y;

   assign dstep_x = div_step(rem_x_ff, dd_x_ff[DIM_W], brick_s[0]);
   assign dstep_y = div_step(rem_y_ff, dd_y_ff[DIM_W], brick_s[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff <= 1'b1;
         busy_ff    <= 1'b0;
         seq_cnt_ff <= '0;
      end else begin
         restart_ff <= csr_write_en;
         if (restart_ff) begin
            busy_ff    <= 1'b1;
            seq_cnt_ff <= '0;
         end else if (busy_ff) begin
            if (seq_cnt_ff == CNT_W'(SEQ_LAST)) begin
               busy_ff <= 1'b0;
            end
            seq_cnt_ff <= seq_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (restart_ff) begin
         dd_x_ff  <= {1'b0, size_s[0]} + {1'b0, brick_s[0]} - (DIM_W+1)'(1);
         dd_y_ff  <= {1'b0, size_s[1]} + {1'b0, brick_s[1]} - (DIM_W+1)'(1);
         rem_x_ff <= '0;
         rem_y_ff <= '0;
         nbx_ff   <= '0;
         nby_ff   <= '0;
      end else if (busy_ff) begin
         if (seq_cnt_ff < CNT_W'(SEQ_DIV_BITS)) begin
            dd_x_ff  <= {dd_x_ff[DIM_W-1:0], 1'b0};
            dd_y_ff  <= {dd_y_ff[DIM_W-1:0], 1'b0};
            rem_x_ff <= dstep_x[DIM_W:1];
            rem_y_ff <= dstep_y[DIM_W:1];
            nbx_ff   <= {nbx_ff[DIM_W-1:0], dstep_x[0]};
            nby_ff   <= {nby_ff[DIM_W-1:0], dstep_y[0]};
         end
         case (seq_cnt_ff)
            CNT_W'(SEQ_DIV_BITS): begin
               inner_z_ff <= brick_s[0] * brick_s[1];
               mul_y_ff   <= (brick_s[1] - DIM_W'(1)) * brick_s[0];
            end
            CNT_W'(SEQ_DIV_BITS + 1): begin
               vol_ff <= STEP_W'(inner_z_ff * brick_s[2]);
            end
            CNT_W'(SEQ_DIV_BITS + 2): begin
               outer_y_ff <= STEP_W'(vol_ff * nbx_ff);
               mul_z_ff   <= OFS_W'(inner_z_ff * (brick_s[2] - DIM_W'(1)));
            end
            CNT_W'(SEQ_DIV_BITS + 3): begin
               outer_z_ff <= STEP_W'(outer_y_ff * nby_ff);
            end
            CNT_W'(SEQ_DIV_BITS + 4): begin
               carry_ff[0] <= $signed(vol_ff) -
                              $signed(STEP_W'(brick_s[0] - DIM_W'(1)));
               carry_ff[1] <= $signed(outer_y_ff) - $signed(STEP_W'(mul_y_ff));
               carry_ff[2] <= $signed(outer_z_ff) - $signed(STEP_W'(mul_z_ff));
            end
            default: ;
         endcase
      end
   end

   // Per-axis stride of a whole brick (outer) and of one index inside a brick (inner).
   logic [STEP_W-1:0] outer_s [NAXES];
   logic [OFS_W-1:0]  inner_s [NAXES];
   assign outer_s[0] = vol_ff;
   assign outer_s[1] = outer_y_ff;
   assign outer_s[2] = outer_z_ff;
   assign inner_s[0] = OFS_W'(1);
   assign inner_s[1] = OFS_W'(brick_s[0]);
   assign inner_s[2] = OFS_W'(inner_z_ff);

   // Global advance: the pipeline moves whenever the result register can take a value.
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance || busy_ff || restart_ff;

   // Stage 1: periodic wrap and border check.
   logic signed [COORD_W-1:0] coord_s [NAXES];
   assign coord_s[0] = req_coord_x;
   assign coord_s[1] = req_coord_y;
   assign coord_s[2] = req_coord_z;

   div_vec_type            s1_axes_in, s1_axes_ff;
   logic [NAXES-1:0]       s1_inside_in, s1_last_in;
   logic [NAXES-1:0]       s1_inside_ff, s1_last_ff;
   logic                   s1_valid_ff;

   always_comb begin
      logic signed [COORD_W:0] cs, sz, lo, hi, w13;
      for (int a = 0; a < NAXES; a++) begin
         cs = {coord_s[a][COORD_W-1], coord_s[a]};
         sz = $signed({2'b00, size_s[a]});
         lo = -$signed({2'b00, bw_s[a]});
         hi = sz + $signed({2'b00, bw_s[a]});
         s1_inside_in[a] = (cs >= lo) && (cs < hi);
         if (cs < 0) begin
            w13 = cs + sz;
         end else if (cs >= sz) begin
            w13 = cs - sz;
         end else begin
            w13 = cs;
         end
         s1_axes_in[a].w   = w13[DIM_W-1:0];
         s1_axes_in[a].quo = '0;
         s1_axes_in[a].rem = '0;
         s1_last_in[a] = ({1'b0, w13[DIM_W-1:0]} + (DIM_W+1)'(1)) == {1'b0, size_s[a]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid && !req_stall;
      end
      if (advance) begin
         s1_axes_ff   <= s1_axes_in;
         s1_inside_ff <= s1_inside_in;
         s1_last_ff   <= s1_last_in;
      end
   end

   // Stages 2 to 4: index divided by brick edge, four, four and three bits.
   div_vec_type s2_axes, s3_axes, s4_axes;
   logic        s2_valid, s3_valid, s4_valid;

   tvag_div_stage #(.FIRST_BIT(DIM_W - 1), .STEPS(4)) u_div_a (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s1_valid_ff), .in_axes(s1_axes_ff), .brick(brick_s),
      .out_valid(s2_valid), .out_axes(s2_axes)
   );
   tvag_div_stage #(.FIRST_BIT(DIM_W - 5), .STEPS(4)) u_div_b (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s2_valid), .in_axes(s2_axes), .brick(brick_s),
      .out_valid(s3_valid), .out_axes(s3_axes)
   );
   tvag_div_stage #(.FIRST_BIT(DIM_W - 9), .STEPS(DIM_W - 8)) u_div_c (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s3_valid), .in_axes(s3_axes), .brick(brick_s),
      .out_valid(s4_valid), .out_axes(s4_axes)
   );

   // The flags ride beside the divider in a short shift line.
   logic [2:0][NAXES-1:0] inside_line_ff, last_line_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         inside_line_ff <= {inside_line_ff[1:0], s1_inside_ff};
         last_line_ff   <= {last_line_ff[1:0], s1_last_ff};
      end
   end

   // Stage 5: brick and in-brick products; choose the step for a non-last index.
   logic [STEP_W-1:0]        s5_pq_ff [NAXES];
   logic [STEP_W-1:0]        s5_pr_ff [NAXES];
   logic signed [STEP_W-1:0] s5_base_ff [NAXES];
   logic [NAXES-1:0]         s5_inside_ff, s5_last_ff;
   logic                     s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid;
      end
      if (advance) begin
         for (int a = 0; a < NAXES; a++) begin
            s5_pq_ff[a] <= STEP_W'(s4_axes[a].quo * outer_s[a]);
            s5_pr_ff[a] <= STEP_W'(s4_axes[a].rem * inner_s[a]);
            if (({1'b0, s4_axes[a].rem} + (DIM_W+1)'(1)) == {1'b0, brick_s[a]}) begin
               s5_base_ff[a] <= carry_ff[a];
            end else begin
               s5_base_ff[a] <= $signed({1'b0, inner_s[a]});
            end
         end
         s5_inside_ff <= inside_line_ff[2];
         s5_last_ff   <= last_line_ff[2];
      end
   end

   // Stage 6: per-axis jump and the outside flag.
   logic [STEP_W-1:0]        s6_j_ff [NAXES];
   logic signed [STEP_W-1:0] s6_base_ff [NAXES];
   logic [NAXES-1:0]         s6_last_ff;
   logic                     s6_outside_ff;
   logic                     s6_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         for (int a = 0; a < NAXES; a++) begin
            s6_j_ff[a]    <= s5_pq_ff[a] + s5_pr_ff[a];
            s6_base_ff[a] <= s5_base_ff[a];
         end
         s6_last_ff    <= s5_last_ff;
         s6_outside_ff <= !(&s5_inside_ff);
      end
   end

   // Stage 7: offset sum, wrap step at the last index, zeroing when outside.
   logic [OFS_W-1:0]         offset_ff;
   logic signed [STEP_W-1:0] step_ff [NAXES];
   logic                     outside_ff;
   logic [STEP_W-1:0]        ofs_sum;

   assign ofs_sum = s6_j_ff[0] + s6_j_ff[1] + s6_j_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s6_valid_ff;
      end
      if (advance) begin
         outside_ff <= s6_outside_ff;
         offset_ff  <= s6_outside_ff ? '0 : ofs_sum[OFS_W-1:0];
         for (int a = 0; a < NAXES; a++) begin
            if (s6_outside_ff) begin
               step_ff[a] <= '0;
            end else if (s6_last_ff[a]) begin
               step_ff[a] <= -$signed(s6_j_ff[a]);
            end else begin
               step_ff[a] <= s6_base_ff[a];
            end
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_offset  = offset_ff;
   assign rsp_step_x  = step_ff[0];
   assign rsp_step_y  = step_ff[1];
   assign rsp_step_z  = step_ff[2];
   assign rsp_outside = outside_ff;

endmodule

### sv/tvag_checker.sv
// Port-level checker for the tiled volume address generator and its bind.
module tvag_checker
   import tvag_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic        [OFS_W-1:0]   rsp_offset,
   input logic signed [STEP_W-1:0]  rsp_step_x,
   input logic signed [STEP_W-1:0]  rsp_step_y,
   input logic signed [STEP_W-1:0]  rsp_step_z,
   input logic                      rsp_outside,
   input logic                      csr_write_en
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_offset))
      else $error("stalled result changed");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside |-> rsp_offset == '0 && rsp_step_x == '0 &&
                                   rsp_step_y == '0 && rsp_step_z == '0)
      else $error("outside result carries nonzero fields");

   a_cfg_recompute: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> req_stall)
      else $error("input taken while derived constants are stale");

   a_reset_recompute: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input taken right after reset");

endmodule

bind tiled_volume_address_gen tvag_checker u_tvag_checker (
   .clock(clock), .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_offset(rsp_offset), .rsp_step_x(rsp_step_x),
   .rsp_step_y(rsp_step_y), .rsp_step_z(rsp_step_z),
   .rsp_outside(rsp_outside), .csr_write_en(csr_write_en)
);
